/* hdl/sipq_pkg.sv */
// ============================================================================
// sipq_pkg
// Shared codes for the sorted-insert priority queue: request opcodes and
// result status values.
// ============================================================================
package sipq_pkg;

    // Request opcode carried on the slave-side tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status carried on the master-side tuser
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

/* hdl/sipq_store.sv */
// ============================================================================
// sipq_store
// Entry memory: one write port and one read port with registered read data.
// Contents are undefined until written.
// ============================================================================
module sipq_store
    import sipq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 32,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [PRIORITY_BITS-1:0] i_wr_prio,
    input  logic [PAYLOAD_BITS-1:0]  i_wr_data,
    input  logic [AW-1:0]            i_rd_addr,
    output logic [PRIORITY_BITS-1:0] o_rd_prio,
    output logic [PAYLOAD_BITS-1:0]  o_rd_data
);

    logic [PRIORITY_BITS-1:0] r_prio_mem [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0]  r_data_mem [QUEUE_DEPTH];

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_prio_mem[i_wr_addr] <= i_wr_prio;
            r_data_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry every cycle
    always_ff @(posedge i_clk) begin
        o_rd_prio <= r_prio_mem[i_rd_addr];
        o_rd_data <= r_data_mem[i_rd_addr];
    end

endmodule

/* hdl/sipq_ctrl.sv */
// ============================================================================
// sipq_ctrl
// Sequencer for the queue. Entries sit in a circular buffer in logical
// sorted order from the head. An insert walks back from the tail one entry
// per read/compare pair, moving larger entries up by one slot; a remove
// reads the head and advances it.
// ============================================================================
module sipq_ctrl
    import sipq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 32,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request side
    input  logic                     i_req_valid,
    output logic                     o_req_ready,
    input  logic                     i_req_op,
    input  logic [PRIORITY_BITS-1:0] i_req_prio,
    input  logic [PAYLOAD_BITS-1:0]  i_req_data,
    // result side
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output t_status                  o_res_status,
    output logic [PRIORITY_BITS-1:0] o_res_prio,
    output logic [PAYLOAD_BITS-1:0]  o_res_data,
    output logic [CW-1:0]            o_res_occ,
    // entry memory
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic [PRIORITY_BITS-1:0] o_wr_prio,
    output logic [PAYLOAD_BITS-1:0]  o_wr_data,
    output logic [AW-1:0]            o_rd_addr,
    input  logic [PRIORITY_BITS-1:0] i_rd_prio,
    input  logic [PAYLOAD_BITS-1:0]  i_rd_data
);

    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_PUT,
        S_POP,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [AW-1:0]            r_head;
    logic [CW-1:0]            r_count;
    logic [AW-1:0]            r_pos;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic [PAYLOAD_BITS-1:0]  r_data;
    t_status                  r_res_status;
    logic [PRIORITY_BITS-1:0] r_res_prio;
    logic [PAYLOAD_BITS-1:0]  r_res_data;

    logic [AW-1:0] pos_phys;
    logic [AW-1:0] prev_phys;
    logic [AW-1:0] next_head;
    logic          move_up;

    // Map a logical position from the head to a buffer slot
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] k);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, k};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign pos_phys  = f_phys(r_head, r_pos);
    assign prev_phys = f_phys(r_head, r_pos - AW'(1));
    assign next_head = f_phys(r_head, AW'(1));

    // Shared compare: the stored entry moves up when it ranks after the new one
    assign move_up = (i_rd_prio > r_prio);

    // Drive the memory ports
    always_comb begin
        o_rd_addr = (r_state == S_RD) ? prev_phys : r_head;
        o_wr_en   = 1'b0;
        o_wr_addr = pos_phys;
        o_wr_prio = r_prio;
        o_wr_data = r_data;
        unique case (r_state)
            S_CMP: begin
                o_wr_en = 1'b1;
                if (move_up) begin
                    o_wr_prio = i_rd_prio;
                    o_wr_data = i_rd_data;
                end
            end
            S_PUT: begin
                o_wr_en = 1'b1;
            end
            default: begin
                o_wr_en = 1'b0;
            end
        endcase
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res_status = r_res_status;
    assign o_res_prio   = r_res_prio;
    assign o_res_data   = r_res_data;
    assign o_res_occ    = r_count;

    // Sequencer state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_prio       <= i_req_prio;
                        r_data       <= i_req_data;
                        r_res_status <= ST_DONE;
                        r_res_prio   <= '0;
                        r_res_data   <= '0;
                        r_pos        <= r_count[AW-1:0];
                        if (i_req_op == OP_INSERT) begin
                            if (r_count == DEPTH_C) begin
                                r_res_status <= ST_FULL;
                                r_state      <= S_DONE;
                            end else if (r_count == '0) begin
                                r_state <= S_PUT;
                            end else begin
                                r_state <= S_RD;
                            end
                        end else begin
                            if (r_count == '0) begin
                                r_res_status <= ST_EMPTY;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_POP;
                            end
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (move_up) begin
                        // entry moved up; step back toward the head
                        r_pos <= r_pos - AW'(1);
                        if (r_pos == AW'(1)) begin
                            r_state <= S_PUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end else begin
                        // new entry written behind the smaller or equal one
                        r_count <= r_count + CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_POP: begin
                    r_res_prio <= i_rd_prio;
                    r_res_data <= i_rd_data;
                    r_head     <= next_head;
                    r_count    <= r_count - CW'(1);
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/sorted_insert_priority_queue_top.sv */
// A rejected request goes straight to its result; a remove reads the head entry; an
// insert reads and compares stored entries from the tail toward the head (one memory
// read and one compare per entry, through the single shared read port), moves larger
// ones up, and writes at the head or behind a smaller or equal one. Throughput: one
// request at a time; the next is taken the cycle after the result enters the output
// register. Reset (sync, active low) clears the queue and output register only.
// ============================================================================
// sorted_insert_priority_queue_top
// Bounded priority queue kept in sorted order over a circular entry memory,
// with stream ports and an output register between sequencer and sink.
// ============================================================================
module sorted_insert_priority_queue_top
    import sipq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 32,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int IW = ((PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
    localparam int OW = ((PRIORITY_BITS + PAYLOAD_BITS + CW + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // slave side
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [IW-1:0] s_axis_tdata,   // priority_req, payload
    input  logic          s_axis_tuser,   // opcode
    // master side
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [OW-1:0] m_axis_tdata,   // out_priority, out_payload, occupancy
    output logic [1:0]    m_axis_tuser    // status
);

    localparam int PB = PRIORITY_BITS;
    localparam int DB = PAYLOAD_BITS;

    logic                     res_valid;
    logic                     res_ready;
    t_status                  res_status;
    logic [PB-1:0]            res_prio;
    logic [DB-1:0]            res_data;
    logic [CW-1:0]            res_occ;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [PB-1:0]            wr_prio;
    logic [DB-1:0]            wr_data;
    logic [AW-1:0]            rd_addr;
    logic [PB-1:0]            rd_prio;
    logic [DB-1:0]            rd_data;

    logic                     r_m_valid;
    t_status                  r_m_status;
    logic [PB-1:0]            r_m_prio;
    logic [DB-1:0]            r_m_data;
    logic [CW-1:0]            r_m_occ;

    sipq_ctrl #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_req_op     (s_axis_tuser),
        .i_req_prio   (s_axis_tdata[PB-1:0]),
        .i_req_data   (s_axis_tdata[PB+DB-1:PB]),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res_status (res_status),
        .o_res_prio   (res_prio),
        .o_res_data   (res_data),
        .o_res_occ    (res_occ),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_prio    (wr_prio),
        .o_wr_data    (wr_data),
        .o_rd_addr    (rd_addr),
        .i_rd_prio    (rd_prio),
        .i_rd_data    (rd_data)
    );

    sipq_store #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_prio (wr_prio),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_prio (rd_prio),
        .o_rd_data (rd_data)
    );

    // Output register takes a result when empty or being drained
    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            if (res_ready) begin
                r_m_valid <= res_valid;
            end
        end
    end

    // Hold result payload until taken
    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_status <= res_status;
            r_m_prio   <= res_prio;
            r_m_data   <= res_data;
            r_m_occ    <= res_occ;
        end
    end

    // Pack the master-side ports
    always_comb begin
        m_axis_tdata                         = '0;
        m_axis_tdata[PB-1:0]                 = r_m_prio;
        m_axis_tdata[PB+DB-1:PB]             = r_m_data;
        m_axis_tdata[PB+DB+CW-1:PB+DB]       = r_m_occ;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;

endmodule
